### hdl/scroll_dirty_column_tracker_assert.svh
// assertion macros for the scroll dirty column tracker checker
// expects clk and rst_n in the scope that uses them
`ifndef SCROLL_DIRTY_COLUMN_TRACKER_ASSERT_SVH
`define SCROLL_DIRTY_COLUMN_TRACKER_ASSERT_SVH

// same-cycle implication
`define SDCT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdct check failed");

// next-cycle implication
`define SDCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdct check failed");

`endif

### hdl/sdct_pkg.sv
// shared constants, codes and types of the scroll dirty column tracker
// no dependencies
package sdct_pkg;

  localparam int COLUMNS    = 16;
  localparam int COL_W      = 4;
  localparam int POS_W      = 5;
  localparam int MAX_ROWS   = 32;
  localparam int TOP_W      = 7;
  localparam int BOT_W      = 5;
  localparam int VIS_W      = 6;
  localparam int TILE_W     = 3;
  localparam int BASE_W     = 5;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SCOL_W     = 6;
  localparam int ROW_W      = 5;
  localparam int HGT_W      = 6;

  typedef enum logic [KIND_W-1:0] {
    KIND_MARK  = 2'd0,
    KIND_SHIFT = 2'd1,
    KIND_SCAN  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  localparam logic [CFG_IDX_W-1:0] CFG_VISIBLE_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLUMNS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_BASE  = 2'd3;

  localparam logic [VIS_W-1:0]  VISIBLE_ROWS_RST = 6'd16;
  localparam logic [TILE_W-1:0] TILE_ROWS_RST    = 3'd2;
  localparam logic [TILE_W-1:0] TILE_COLUMNS_RST = 3'd2;
  localparam logic [BASE_W-1:0] COLUMN_BASE_RST  = 5'd12;

  typedef struct packed {
    logic signed [TOP_W-1:0] top;
    logic [BOT_W-1:0]        bottom;
    logic                    clear;
  } shift_res_t;

  typedef struct packed {
    logic [ROW_W-1:0] top_row;
    logic [HGT_W-1:0] height;
  } rect_t;

endpackage

### hdl/sdct_range_alu.sv
// range arithmetic for one column: shift-down update and scan rectangle
// depends on sdct_pkg
module sdct_range_alu (
  input  logic signed [sdct_pkg::TOP_W-1:0] top_i,
  input  logic [sdct_pkg::BOT_W-1:0]        bot_i,
  input  logic [sdct_pkg::VIS_W-1:0]        rows_i,
  output sdct_pkg::shift_res_t              shift_o,
  output sdct_pkg::rect_t                   rect_o
);

  logic signed [sdct_pkg::TOP_W-1:0] top_inc;
  logic [sdct_pkg::VIS_W-1:0]        bot_inc;
  logic [sdct_pkg::ROW_W-1:0]        top_clamp;
  logic signed [sdct_pkg::TOP_W-1:0] diff;

  always_comb begin
    top_inc = top_i + 7'sd1;
    bot_inc = {1'b0, bot_i} + 6'd1;
    shift_o.top    = top_inc;
    shift_o.bottom = (bot_inc < rows_i) ? bot_inc[sdct_pkg::BOT_W-1:0] : bot_i;
    shift_o.clear  = (top_inc >= $signed({1'b0, rows_i}));
    // negative top sits above the visible area
    top_clamp = top_i[sdct_pkg::TOP_W-1] ? '0 : top_i[sdct_pkg::ROW_W-1:0];
    diff = $signed({2'b00, bot_i}) - $signed({2'b00, top_clamp}) + 7'sd1;
    rect_o.top_row = top_clamp;
    rect_o.height  = diff[sdct_pkg::TOP_W-1] ? '0 : diff[sdct_pkg::HGT_W-1:0];
  end

endmodule

### hdl/scroll_dirty_column_tracker.sv
// top level of the scroll dirty column tracker: control, flags and range memories
// depends on sdct_pkg and sdct_range_alu
//
//  channel  | signals                                        | transfer
//  ---------+------------------------------------------------+---------------------
//  in       | in_kind, in_column                             | in_valid & in_ready
//  out      | out_rect_valid, out_screen_column, out_top_row,| out_valid & out_ready
//           | out_height, out_last                           |
//  cfg      | cfg_index, cfg_wdata                           | cfg_we
//
// mark: one column write per cycle
// shift: the single read port walks all 16 range entries in turn
// scan: walks the columns, one result per dirty column, waits while out stalls
// reset clears flags and control; range memories are gated by flags, no clear pass
// in_ready is low while a mark, shift or scan is in progress
module scroll_dirty_column_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [sdct_pkg::KIND_W-1:0]      in_kind,
  input  logic [sdct_pkg::COL_W-1:0]       in_column,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_rect_valid,
  output logic [sdct_pkg::SCOL_W-1:0]      out_screen_column,
  output logic [sdct_pkg::ROW_W-1:0]       out_top_row,
  output logic [sdct_pkg::HGT_W-1:0]       out_height,
  output logic                             out_last,
  input  logic                             cfg_we,
  input  logic [sdct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sdct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_MARK     = 5'b00010,
    S_SHIFT    = 5'b00100,
    S_SCAN_RD  = 5'b01000,
    S_SCAN_OUT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [sdct_pkg::VIS_W-1:0]  visible_rows_r;
  logic [sdct_pkg::TILE_W-1:0] tile_rows_r;
  logic [sdct_pkg::TILE_W-1:0] tile_columns_r;
  logic [sdct_pkg::BASE_W-1:0] column_base_r;

  logic [sdct_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [sdct_pkg::TILE_W-1:0] cnt_r, cnt_nxt;
  logic [sdct_pkg::COLUMNS-1:0] flag_r, flag_nxt;
  logic                        wb_vld_r;
  logic [sdct_pkg::COL_W-1:0]  wb_idx_r;

  logic signed [sdct_pkg::TOP_W-1:0] top_mem [sdct_pkg::COLUMNS];
  logic [sdct_pkg::BOT_W-1:0]        bot_mem [sdct_pkg::COLUMNS];
  logic signed [sdct_pkg::TOP_W-1:0] top_q_r;
  logic [sdct_pkg::BOT_W-1:0]        bot_q_r;

  logic                              top_we, bot_we;
  logic [sdct_pkg::COL_W-1:0]        top_wa, bot_wa;
  logic signed [sdct_pkg::TOP_W-1:0] top_wd;
  logic [sdct_pkg::BOT_W-1:0]        bot_wd;

  logic                              out_valid_r;
  logic                              out_rect_valid_r, out_last_r;
  logic [sdct_pkg::SCOL_W-1:0]       out_screen_column_r;
  logic [sdct_pkg::ROW_W-1:0]        out_top_row_r;
  logic [sdct_pkg::HGT_W-1:0]        out_height_r;

  logic [sdct_pkg::VIS_W-1:0]        eff_rows;
  sdct_pkg::shift_res_t              shift_res;
  sdct_pkg::rect_t                   rect;
  logic [sdct_pkg::COL_W-1:0]        pos_col;
  logic                              pos_in_range;
  logic                              no_flags;
  logic [sdct_pkg::COLUMNS-1:0]      above_mask;
  logic                              last_w;
  logic                              slot_free;
  logic                              out_load;
  logic                              accept;

  assign pos_col      = pos_r[sdct_pkg::COL_W-1:0];
  assign pos_in_range = (pos_r < sdct_pkg::POS_W'(sdct_pkg::COLUMNS));
  assign no_flags     = ~|flag_r;
  assign eff_rows     = (visible_rows_r > sdct_pkg::VIS_W'(sdct_pkg::MAX_ROWS)) ?
                        sdct_pkg::VIS_W'(sdct_pkg::MAX_ROWS) : visible_rows_r;
  assign slot_free    = !out_valid_r || out_ready;
  assign in_ready     = (state_r == S_IDLE);
  assign accept       = in_valid && in_ready;

  always_comb begin
    for (int i = 0; i < sdct_pkg::COLUMNS; i++) begin
      above_mask[i] = (sdct_pkg::POS_W'(i) > pos_r);
    end
  end
  assign last_w = ~|(flag_r & above_mask);

  sdct_range_alu u_alu (
    .top_i   (top_q_r),
    .bot_i   (bot_q_r),
    .rows_i  (eff_rows),
    .shift_o (shift_res),
    .rect_o  (rect)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      visible_rows_r <= sdct_pkg::VISIBLE_ROWS_RST;
      tile_rows_r    <= sdct_pkg::TILE_ROWS_RST;
      tile_columns_r <= sdct_pkg::TILE_COLUMNS_RST;
      column_base_r  <= sdct_pkg::COLUMN_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdct_pkg::CFG_VISIBLE_ROWS: visible_rows_r <= cfg_wdata;
        sdct_pkg::CFG_TILE_ROWS:    tile_rows_r    <= cfg_wdata[sdct_pkg::TILE_W-1:0];
        sdct_pkg::CFG_TILE_COLUMNS: tile_columns_r <= cfg_wdata[sdct_pkg::TILE_W-1:0];
        sdct_pkg::CFG_COLUMN_BASE:  column_base_r  <= cfg_wdata[sdct_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // memory write side and flags
  always_comb begin
    top_we   = 1'b0;
    bot_we   = 1'b0;
    top_wa   = pos_col;
    bot_wa   = pos_col;
    top_wd   = shift_res.top;
    bot_wd   = shift_res.bottom;
    flag_nxt = flag_r;
    priority if (state_r == S_MARK && pos_in_range) begin
      top_we = 1'b1;
      top_wd = ~{{(sdct_pkg::TOP_W-sdct_pkg::TILE_W){1'b0}}, tile_rows_r};
      bot_we = !flag_r[pos_col];
      bot_wd = '0;
      flag_nxt[pos_col] = 1'b1;
    end else if (wb_vld_r && flag_r[wb_idx_r]) begin
      top_wa = wb_idx_r;
      bot_wa = wb_idx_r;
      if (shift_res.clear) begin
        flag_nxt[wb_idx_r] = 1'b0;
      end else begin
        top_we = 1'b1;
        bot_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (top_we) begin
      top_mem[top_wa] <= top_wd;
    end
    if (bot_we) begin
      bot_mem[bot_wa] <= bot_wd;
    end
    top_q_r <= top_mem[pos_col];
    bot_q_r <= bot_mem[pos_col];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          pos_nxt = '0;
          unique case (sdct_pkg::kind_t'(in_kind))
            sdct_pkg::KIND_MARK: begin
              pos_nxt = {1'b0, in_column};
              cnt_nxt = tile_columns_r;
              if (tile_columns_r != '0) begin
                state_nxt = S_MARK;
              end
            end
            sdct_pkg::KIND_SHIFT: state_nxt = S_SHIFT;
            sdct_pkg::KIND_SCAN:  state_nxt = S_SCAN_RD;
            sdct_pkg::KIND_NONE:  ;
            default: ;
          endcase
        end
      end
      S_MARK: begin
        pos_nxt = pos_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == sdct_pkg::TILE_W'(1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_SHIFT: begin
        pos_nxt = pos_r + 1'b1;
        if (pos_col == sdct_pkg::COL_W'(sdct_pkg::COLUMNS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN_RD: begin
        if (no_flags || flag_r[pos_col]) begin
          state_nxt = S_SCAN_OUT;
        end else begin
          pos_nxt = pos_r + 1'b1;
        end
      end
      S_SCAN_OUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          if (no_flags || last_w) begin
            state_nxt = S_IDLE;
          end else begin
            pos_nxt   = pos_r + 1'b1;
            state_nxt = S_SCAN_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      flag_r      <= '0;
      wb_vld_r    <= 1'b0;
      wb_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      cnt_r    <= cnt_nxt;
      flag_r   <= flag_nxt;
      wb_vld_r <= (state_r == S_SHIFT);
      wb_idx_r <= pos_col;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (no_flags) begin
        out_rect_valid_r    <= 1'b0;
        out_screen_column_r <= '0;
        out_top_row_r       <= '0;
        out_height_r        <= '0;
        out_last_r          <= 1'b1;
      end else begin
        out_rect_valid_r    <= 1'b1;
        out_screen_column_r <= sdct_pkg::SCOL_W'(column_base_r) + sdct_pkg::SCOL_W'(pos_col);
        out_top_row_r       <= rect.top_row;
        out_height_r        <= rect.height;
        out_last_r          <= last_w;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rect_valid    = out_rect_valid_r;
  assign out_screen_column = out_screen_column_r;
  assign out_top_row       = out_top_row_r;
  assign out_height        = out_height_r;
  assign out_last          = out_last_r;

endmodule

### hdl/sdct_checker.sv
// port-level checks of the scroll dirty column tracker, bound to the top level
// depends on sdct_pkg and scroll_dirty_column_tracker_assert.svh
`include "scroll_dirty_column_tracker_assert.svh"

module sdct_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             out_rect_valid,
  input logic [sdct_pkg::SCOL_W-1:0]      out_screen_column,
  input logic [sdct_pkg::ROW_W-1:0]       out_top_row,
  input logic [sdct_pkg::HGT_W-1:0]       out_height,
  input logic                             out_last
);

  // a stalled result stays offered
  `SDCT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // a stalled result keeps its payload
  `SDCT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_rect_valid) && $stable(out_screen_column) && $stable(out_top_row) && $stable(out_height) && $stable(out_last))

  // the empty scan result is all zero and closes the scan
  `SDCT_ASSERT_SAME(a_empty_shape, out_valid && !out_rect_valid, out_last && out_screen_column == '0 && out_top_row == '0 && out_height == '0)

  // a dirty rectangle covers at least one row and is no taller than MAX_ROWS
  `SDCT_ASSERT_SAME(a_rect_height, out_valid && out_rect_valid, out_height != '0 && out_height <= sdct_pkg::HGT_W'(sdct_pkg::MAX_ROWS))

endmodule

bind scroll_dirty_column_tracker sdct_checker u_sdct_checker (.*);

### tb/sv/scroll_dirty_column_tracker_test.sv
// self-checking testbench for scroll_dirty_column_tracker: queue-fed driver, clocked monitor
// and an in-bench predictor of the per-column dirty ranges; needs sdct_pkg and the block's rtl
`timescale 1ns / 1ps

module scroll_dirty_column_tracker_test;

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int PHASE_OPS = 60;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    sdct_pkg::kind_t            kind;
    logic [sdct_pkg::COL_W-1:0] column;
  } tracker_op_t;

  typedef struct packed {
    logic                        rect_valid;
    logic [sdct_pkg::SCOL_W-1:0] screen_column;
    logic [sdct_pkg::ROW_W-1:0]  top_row;
    logic [sdct_pkg::HGT_W-1:0]  height;
    logic                        last;
  } rect_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [sdct_pkg::KIND_W-1:0]     in_kind = '0;
  logic [sdct_pkg::COL_W-1:0]      in_column = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            out_rect_valid;
  logic [sdct_pkg::SCOL_W-1:0]     out_screen_column;
  logic [sdct_pkg::ROW_W-1:0]      out_top_row;
  logic [sdct_pkg::HGT_W-1:0]      out_height;
  logic                            out_last;
  logic                            cfg_we = 1'b0;
  logic [sdct_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sdct_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic                              col_flag [sdct_pkg::COLUMNS];
  logic signed [sdct_pkg::TOP_W-1:0] col_top [sdct_pkg::COLUMNS];
  logic [sdct_pkg::BOT_W-1:0]        col_bot [sdct_pkg::COLUMNS];
  logic [sdct_pkg::VIS_W-1:0]        vis_rows_q;
  logic [sdct_pkg::TILE_W-1:0]       tile_rows_q;
  logic [sdct_pkg::TILE_W-1:0]       tile_cols_q;
  logic [sdct_pkg::BASE_W-1:0]       base_q;

  tracker_op_t  op_queue [$];
  rect_result_t pending_rects [$];
  tracker_op_t  next_op;

  logic in_taken = 1'b0;
  bit   idling_on = 1'b1;
  int   in_gap = 0;
  int   out_gap = 0;
  int   hold_left = 0;
  int   stall_asks = 0;
  int   stall_done = 0;
  int   cycle_count = 0;
  int   mismatches = 0;
  int   n_marks = 0;
  int   n_shifts = 0;
  int   n_scans = 0;
  int   n_rects = 0;
  int   n_settings = 1;

  scroll_dirty_column_tracker i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_column         (in_column),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rect_valid    (out_rect_valid),
    .out_screen_column (out_screen_column),
    .out_top_row       (out_top_row),
    .out_height        (out_height),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [sdct_pkg::COL_W-1:0] pick_column();
    return sdct_pkg::COL_W'($urandom_range(0, sdct_pkg::COLUMNS - 1));
  endfunction

  function automatic int rows_in_view();
    int r;
    r = int'(vis_rows_q);
    return (r < sdct_pkg::MAX_ROWS) ? r : sdct_pkg::MAX_ROWS;
  endfunction

  function automatic void apply_mark(logic [sdct_pkg::COL_W-1:0] first);
    int c;
    for (int j = 0; j < int'(tile_cols_q); j++) begin
      c = int'(first) + j;
      if (c < sdct_pkg::COLUMNS) begin
        col_top[c] = sdct_pkg::TOP_W'(-int'(tile_rows_q) - 1);
        if (!col_flag[c]) col_bot[c] = '0;
        col_flag[c] = 1'b1;
      end
    end
  endfunction

  function automatic void apply_shift();
    int r;
    int t;
    r = rows_in_view();
    for (int i = 0; i < sdct_pkg::COLUMNS; i++) begin
      if (col_flag[i]) begin
        if (int'(col_bot[i]) < r - 1) col_bot[i] = col_bot[i] + 1'b1;
        t = int'(col_top[i]) + 1;
        if (t >= r) begin
          col_flag[i] = 1'b0;
          col_top[i] = '0;
          col_bot[i] = '0;
        end else begin
          col_top[i] = sdct_pkg::TOP_W'(t);
        end
      end
    end
  endfunction

  function automatic void predict_scan();
    rect_result_t held;
    bit have;
    int top;
    int h;
    have = 1'b0;
    held = '0;
    for (int i = 0; i < sdct_pkg::COLUMNS; i++) begin
      if (col_flag[i]) begin
        if (have) pending_rects.push_back(held);
        top = int'(col_top[i]);
        if (top < 0) top = 0;
        h = int'(col_bot[i]) - top + 1;
        if (h < 0) h = 0;
        held.rect_valid = 1'b1;
        held.screen_column = sdct_pkg::SCOL_W'(int'(base_q) + i);
        held.top_row = sdct_pkg::ROW_W'(top);
        held.height = sdct_pkg::HGT_W'(h);
        held.last = 1'b0;
        have = 1'b1;
      end
    end
    if (!have) held = '0;
    held.last = 1'b1;
    pending_rects.push_back(held);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // monitor: predicts on input transfers, checks on output transfers
  always @(posedge clk) begin
    rect_result_t want;
    cycle_count++;
    if (!rst_n) begin
      in_taken <= 1'b0;
      vis_rows_q = sdct_pkg::VISIBLE_ROWS_RST;
      tile_rows_q = sdct_pkg::TILE_ROWS_RST;
      tile_cols_q = sdct_pkg::TILE_COLUMNS_RST;
      base_q = sdct_pkg::COLUMN_BASE_RST;
      for (int i = 0; i < sdct_pkg::COLUMNS; i++) begin
        col_flag[i] = 1'b0;
        col_top[i] = '0;
        col_bot[i] = '0;
      end
    end else begin
      in_taken <= in_valid && in_ready;
      if (cfg_we) begin
        case (cfg_index)
          sdct_pkg::CFG_VISIBLE_ROWS: vis_rows_q = cfg_wdata[sdct_pkg::VIS_W-1:0];
          sdct_pkg::CFG_TILE_ROWS:    tile_rows_q = cfg_wdata[sdct_pkg::TILE_W-1:0];
          sdct_pkg::CFG_TILE_COLUMNS: tile_cols_q = cfg_wdata[sdct_pkg::TILE_W-1:0];
          sdct_pkg::CFG_COLUMN_BASE:  base_q = cfg_wdata[sdct_pkg::BASE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        case (sdct_pkg::kind_t'(in_kind))
          sdct_pkg::KIND_MARK: begin
            apply_mark(in_column);
            n_marks++;
          end
          sdct_pkg::KIND_SHIFT: begin
            apply_shift();
            n_shifts++;
          end
          sdct_pkg::KIND_SCAN: begin
            predict_scan();
            n_scans++;
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (pending_rects.size() == 0) begin
          $error("result transfer with no result expected");
          mismatches++;
        end else begin
          want = pending_rects.pop_front();
          check_field("rect_valid", int'(want.rect_valid), int'(out_rect_valid));
          check_field("screen_column", int'(want.screen_column), int'(out_screen_column));
          check_field("top_row", int'(want.top_row), int'(out_top_row));
          check_field("height", int'(want.height), int'(out_height));
          check_field("last", int'(want.last), int'(out_last));
          n_rects++;
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (op_queue.size() != 0) begin
        next_op = op_queue.pop_front();
        in_valid <= 1'b1;
        in_kind <= next_op.kind;
        in_column <= next_op.column;
        in_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_done != stall_asks) begin
        stall_done = stall_asks;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (out_gap > 0) begin
        out_ready <= 1'b0;
        out_gap--;
      end else begin
        out_ready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  task automatic add_op(sdct_pkg::kind_t kind, logic [sdct_pkg::COL_W-1:0] column);
    tracker_op_t op;
    op.kind = kind;
    op.column = column;
    op_queue.push_back(op);
  endtask

  task automatic write_reg(logic [sdct_pkg::CFG_IDX_W-1:0] idx,
                           logic [sdct_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
  endtask

  task automatic wait_drained();
    while (op_queue.size() != 0 || in_valid || pending_rects.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly mark-and-scroll sweeps with scans on the way, plus loose items
  task automatic queue_random_ops(int count);
    int added;
    int pick;
    int len;
    int remark_odds;
    logic [sdct_pkg::COL_W-1:0] col;
    added = 0;
    while (added < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        col = pick_column();
        add_op(sdct_pkg::KIND_MARK, col);
        added++;
        len = $urandom_range(1, 48);
        remark_odds = $urandom_range(0, 1) ? 4 : 0;
        for (int k = 0; k < len && added < count; k++) begin
          if (remark_odds != 0 && $urandom_range(1, remark_odds) == 1) begin
            add_op(sdct_pkg::KIND_MARK, col);
            added++;
          end
          add_op(sdct_pkg::KIND_SHIFT, pick_column());
          added++;
          if ($urandom_range(0, 1) == 0) begin
            add_op(sdct_pkg::KIND_SCAN, pick_column());
            added++;
          end
        end
      end else if (pick < 55) begin
        add_op(sdct_pkg::KIND_MARK, pick_column());
        added++;
      end else if (pick < 75) begin
        add_op(sdct_pkg::KIND_SHIFT, pick_column());
        added++;
      end else if (pick < 95) begin
        add_op(sdct_pkg::KIND_SCAN, pick_column());
        added++;
      end else begin
        add_op(sdct_pkg::KIND_NONE, pick_column());
      end
    end
  endtask

  initial begin
    int vr;
    int tr;
    int tc;
    int cb;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty scan, edge columns, overlap, unused kind
    add_op(sdct_pkg::KIND_SCAN, 4'd0);
    add_op(sdct_pkg::KIND_MARK, 4'd0);
    add_op(sdct_pkg::KIND_MARK, 4'd15);
    add_op(sdct_pkg::KIND_SCAN, 4'd15);
    add_op(sdct_pkg::KIND_SHIFT, 4'd9);
    add_op(sdct_pkg::KIND_SCAN, 4'd0);
    add_op(sdct_pkg::KIND_NONE, 4'd5);
    add_op(sdct_pkg::KIND_MARK, 4'd14);
    add_op(sdct_pkg::KIND_SCAN, 4'd0);
    add_op(sdct_pkg::KIND_SHIFT, 4'd0);
    add_op(sdct_pkg::KIND_SHIFT, 4'd15);
    add_op(sdct_pkg::KIND_SHIFT, 4'd0);
    add_op(sdct_pkg::KIND_SCAN, 4'd10);
    add_op(sdct_pkg::KIND_MARK, 4'd7);
    add_op(sdct_pkg::KIND_SCAN, 4'd0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin vr = 32; tr = 4; tc = 4; cb = 31; end
        1: begin vr = 1;  tr = 1; tc = 1; cb = 0;  end
        2: begin vr = 0;  tr = 7; tc = 7; cb = 17; end
        3: begin vr = 63; tr = 0; tc = 0; cb = 5;  end
        4: begin vr = 20; tr = 3; tc = 3; cb = 12; end
        5: begin
          vr = $urandom_range(1, 32);
          tr = $urandom_range(1, 4);
          tc = $urandom_range(1, 4);
          cb = $urandom_range(0, 31);
        end
        6: begin
          vr = $urandom_range(0, 63);
          tr = $urandom_range(0, 7);
          tc = $urandom_range(0, 7);
          cb = $urandom_range(0, 31);
        end
        default: begin vr = 32; tr = 7; tc = 4; cb = 31; end
      endcase
      idling_on = (p % 3 != 1);
      write_reg(sdct_pkg::CFG_VISIBLE_ROWS, sdct_pkg::CFG_DATA_W'(vr));
      write_reg(sdct_pkg::CFG_TILE_ROWS, {3'($urandom_range(0, 7)), 3'(tr)});
      write_reg(sdct_pkg::CFG_TILE_COLUMNS, {3'($urandom_range(0, 7)), 3'(tc)});
      write_reg(sdct_pkg::CFG_COLUMN_BASE, {1'($urandom_range(0, 1)), 5'(cb)});
      @(negedge clk);
      cfg_we <= 1'b0;
      n_settings++;
      queue_random_ops(PHASE_OPS);
      // long receiver hold-off while items keep coming
      if (p == 0 || p == 4) stall_asks++;
      wait_drained();
    end

    $display("checked %0d rectangles from %0d scans (%0d marks, %0d shifts)",
             n_rects, n_scans, n_marks, n_shifts);
    $display("over %0d register settings with idle gaps and long output stalls",
             n_settings);
    if (mismatches == 0) begin
      $display("[scroll_dirty_column_tracker] OK");
    end else begin
      $display("[scroll_dirty_column_tracker] ERROR");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("[scroll_dirty_column_tracker] ERROR");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/sdct_pkg.sv
hdl/sdct_range_alu.sv
hdl/scroll_dirty_column_tracker.sv
hdl/sdct_checker.sv
tb/sv/scroll_dirty_column_tracker_test.sv
